[hw/rtl/rds_pkg.sv]
// Package for the reliable datagram sequencer: widths, register map,
// status codes, controller states and the command/status structs.
// No dependencies.
package rds_pkg;

  localparam int SEQ_W   = 31;
  localparam int TIME_W  = 48;
  localparam int LEN_W   = 12;
  localparam int BYTES_W = 13;
  localparam int GAIN_W  = 4;
  localparam int SCALE_W = BYTES_W + GAIN_W;
  localparam int COST_W  = SCALE_W + 16;
  localparam int BACK_W  = 10 + 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int MAX_PAYLOAD  = 2048;
  localparam int HEADER_BYTES = 8;
  localparam int QPORT_BYTES  = 2;

  localparam logic [2:0] REG_IS_CLIENT      = 3'd0;
  localparam logic [2:0] REG_PAYLOAD_LIMIT  = 3'd1;
  localparam logic [2:0] REG_TICKS_PER_BYTE = 3'd2;
  localparam logic [2:0] REG_BACKLOG_LIMIT  = 3'd3;
  localparam logic [2:0] REG_DUP_COUNT      = 3'd4;

  localparam logic [1:0] STAT_SENT     = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_ACCEPTED = 2'd2;
  localparam logic [1:0] STAT_STALE    = 2'd3;

  typedef struct packed {
    logic        is_client;
    logic [11:0] payload_limit;
    logic [15:0] ticks_per_byte;
    logic [9:0]  backlog_limit;
    logic [2:0]  dup_count;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCALE,
    S_COST,
    S_CLEAR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic scale;
    logic cost;
    logic clear;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic send;
  } dp_status_t;

endpackage

[hw/rtl/rds_regs.sv]
// Configuration register file on the APB-style port.
// Depends on rds_pkg.
module rds_regs import rds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.is_client      <= 1'b1;
      cfg.payload_limit  <= 12'd2048;
      cfg.ticks_per_byte <= 16'd400;
      cfg.backlog_limit  <= 10'd200;
      cfg.dup_count      <= 3'd0;
    end else if (wr) begin
      case (index)
        REG_IS_CLIENT:      cfg.is_client      <= pwdata[0];
        REG_PAYLOAD_LIMIT:  cfg.payload_limit  <= pwdata[11:0];
        REG_TICKS_PER_BYTE: cfg.ticks_per_byte <= pwdata[15:0];
        REG_BACKLOG_LIMIT:  cfg.backlog_limit  <= pwdata[9:0];
        REG_DUP_COUNT:      cfg.dup_count      <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_IS_CLIENT:      prdata = {31'd0, cfg.is_client};
      REG_PAYLOAD_LIMIT:  prdata = {20'd0, cfg.payload_limit};
      REG_TICKS_PER_BYTE: prdata = {16'd0, cfg.ticks_per_byte};
      REG_BACKLOG_LIMIT:  prdata = {22'd0, cfg.backlog_limit};
      REG_DUP_COUNT:      prdata = {29'd0, cfg.dup_count};
      default:            prdata = '0;
    endcase
  end

endmodule

[hw/rtl/rds_ctrl.sv]
// Controller state machine: item handshake, step sequencing, result register valid.
// Depends on rds_pkg; drives rds_dp through dp_cmd_t.
module rds_ctrl import rds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t dp_status,
  output dp_cmd_t    dp_cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_DECIDE;
      S_DECIDE: state_next = dp_status.send ? S_SCALE : S_FINISH;
      S_SCALE:  state_next = S_COST;
      S_COST:   state_next = S_CLEAR;
      S_CLEAR:  state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    dp_cmd          = '0;
    out_valid_next  = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        dp_cmd.load = in_valid;
      end
      S_DECIDE: dp_cmd.decide = 1'b1;
      S_SCALE:  dp_cmd.scale  = 1'b1;
      S_COST:   dp_cmd.cost   = 1'b1;
      S_CLEAR:  dp_cmd.clear  = 1'b1;
      S_FINISH: begin
        dp_cmd.load_out = out_free;
        if (out_free) out_valid_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_accept_to_decide: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_DECIDE)
    else $error("accepted item did not enter decide step");

  a_decide_from_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> $past(state) == S_IDLE)
    else $error("decide step entered without an accepted item");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !out_ready) |=> state == S_FINISH)
    else $error("finish step left while result register full");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result valid raised outside finish step");

endmodule

[hw/rtl/rds_dp.sv]
// Datapath: sequencing state, packet sizing, rate cost multiply, clear time and result register.
// Depends on rds_pkg; stepped by rds_ctrl through dp_cmd_t.
module rds_dp import rds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  dp_cmd_t           dp_cmd,
  output dp_status_t        dp_status,
  input  logic              operation,
  input  logic [TIME_W-1:0] now_time,
  input  logic [SEQ_W-1:0]  rx_sequence,
  input  logic              rx_has_reliable,
  input  logic [SEQ_W-1:0]  rx_ack_sequence,
  input  logic              rx_ack_bit,
  input  logic [LEN_W-1:0]  pending_length,
  input  logic [LEN_W-1:0]  unreliable_length,
  input  logic              message_overflow,
  output logic [1:0]        status,
  output logic [31:0]       header_first,
  output logic [31:0]       header_second,
  output logic [LEN_W-1:0]  packet_bytes,
  output logic              sent_reliable,
  output logic              took_pending,
  output logic              unreliable_sent,
  output logic [SEQ_W-1:0]  dropped_gap,
  output logic              reliable_acked,
  output logic              can_packet,
  output logic              can_reliable
);

  // latched item
  logic              op_q;
  logic [TIME_W-1:0] now_q;
  logic [SEQ_W-1:0]  rx_seq_q;
  logic              rx_rel_q;
  logic [SEQ_W-1:0]  rx_ack_q;
  logic              rx_ackbit_q;
  logic [LEN_W-1:0]  pend_q;
  logic [LEN_W-1:0]  unrel_q;
  logic              ovf_q;

  // sequencing state
  logic [SEQ_W-1:0]  out_seq;
  logic [SEQ_W-1:0]  in_seq;
  logic [SEQ_W-1:0]  in_acked_seq;
  logic              peer_ack_bit;
  logic              own_reliable_bit;
  logic              in_reliable_bit;
  logic [SEQ_W-1:0]  last_reliable_seq;
  logic [LEN_W-1:0]  reliable_bytes;
  logic [TIME_W-1:0] clear_time;

  // working result
  logic [1:0]        w_status;
  logic [31:0]       w_hdr1;
  logic [31:0]       w_hdr2;
  logic [LEN_W-1:0]  w_bytes;
  logic              w_sent_rel;
  logic              w_took;
  logic              w_unrel;
  logic [SEQ_W-1:0]  w_gap;
  logic              w_acked;
  logic              send_q;

  logic [BYTES_W-1:0] used_q;
  logic [BACK_W-1:0]  backlog_q;
  logic [SCALE_W-1:0] scaled_q;
  logic [COST_W-1:0]  cost_q;

  // decide step logic
  logic               send;
  logic               rel;
  logic               take;
  logic [LEN_W-1:0]   rb_eff;
  logic [SEQ_W-1:0]   out_seq_inc;
  logic [LEN_W-1:0]   lim;
  logic [BYTES_W-1:0] cap;
  logic [BYTES_W-1:0] used_a;
  logic [BYTES_W-1:0] used_s;
  logic [BYTES_W-1:0] room;
  logic               unrel_ok;
  logic [BYTES_W-1:0] used_f;
  logic               stale;
  logic               acked;
  logic [GAIN_W-1:0]  gain;
  logic [TIME_W-1:0]  base;
  logic [TIME_W:0]    sum;
  logic [TIME_W:0]    limit_time;
  logic               choke_free;

  assign send        = !op_q && !ovf_q;
  assign take        = (reliable_bytes == '0) && (pend_q != '0);
  assign rel         = take || ((in_acked_seq > last_reliable_seq) &&
                                (peer_ack_bit != own_reliable_bit));
  assign rb_eff      = take ? pend_q : reliable_bytes;
  assign out_seq_inc = out_seq + SEQ_W'(1);
  assign lim         = (cfg.payload_limit < LEN_W'(MAX_PAYLOAD)) ? cfg.payload_limit
                                                                 : LEN_W'(MAX_PAYLOAD);
  assign cap         = {1'b0, lim} + BYTES_W'(HEADER_BYTES);
  assign used_a      = BYTES_W'(HEADER_BYTES) +
                       (cfg.is_client ? BYTES_W'(QPORT_BYTES) : '0) +
                       (rel ? {1'b0, rb_eff} : '0);
  assign used_s      = (used_a > cap) ? cap : used_a;
  assign room        = cap - used_s;
  assign unrel_ok    = room >= {1'b0, unrel_q};
  assign used_f      = unrel_ok ? used_s + {1'b0, unrel_q} : used_s;
  assign stale       = rx_seq_q <= in_seq;
  assign acked       = rx_ackbit_q == own_reliable_bit;
  assign gain        = {1'b0, cfg.dup_count} + GAIN_W'(1);
  assign base        = (clear_time < now_q) ? now_q : clear_time;
  assign sum         = {1'b0, base} + (TIME_W + 1)'(cost_q);
  assign limit_time  = {1'b0, now_q} + (TIME_W + 1)'(backlog_q);
  assign choke_free  = {1'b0, clear_time} < limit_time;

  assign dp_status.send = send;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op_q        <= operation;
      now_q       <= now_time;
      rx_seq_q    <= rx_sequence;
      rx_rel_q    <= rx_has_reliable;
      rx_ack_q    <= rx_ack_sequence;
      rx_ackbit_q <= rx_ack_bit;
      pend_q      <= pending_length;
      unrel_q     <= unreliable_length;
      ovf_q       <= message_overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_seq           <= '0;
      in_seq            <= '0;
      in_acked_seq      <= '0;
      peer_ack_bit      <= 1'b0;
      own_reliable_bit  <= 1'b0;
      in_reliable_bit   <= 1'b0;
      last_reliable_seq <= '0;
      reliable_bytes    <= '0;
      clear_time        <= '0;
    end else begin
      if (dp_cmd.decide) begin
        if (send) begin
          out_seq <= out_seq_inc;
          if (take) begin
            reliable_bytes   <= pend_q;
            own_reliable_bit <= !own_reliable_bit;
          end
          if (rel) last_reliable_seq <= out_seq_inc;
        end else if (op_q && !stale) begin
          if (acked) reliable_bytes <= '0;
          in_seq       <= rx_seq_q;
          in_acked_seq <= rx_ack_q;
          peer_ack_bit <= rx_ackbit_q;
          if (rx_rel_q) in_reliable_bit <= !in_reliable_bit;
        end
      end
      if (dp_cmd.clear && send_q) begin
        clear_time <= sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.decide) begin
      send_q     <= send;
      used_q     <= used_f;
      backlog_q  <= BACK_W'(cfg.backlog_limit) * BACK_W'(cfg.ticks_per_byte);
      w_hdr1     <= '0;
      w_hdr2     <= '0;
      w_bytes    <= '0;
      w_sent_rel <= 1'b0;
      w_took     <= 1'b0;
      w_unrel    <= 1'b0;
      w_gap      <= '0;
      w_acked    <= 1'b0;
      if (!op_q) begin
        w_status <= ovf_q ? STAT_OVERFLOW : STAT_SENT;
        if (!ovf_q) begin
          w_hdr1     <= {rel, out_seq};
          w_hdr2     <= {in_reliable_bit, in_seq};
          w_bytes    <= used_f[LEN_W-1:0];
          w_sent_rel <= rel;
          w_took     <= take;
          w_unrel    <= unrel_ok;
        end
      end else begin
        w_status <= stale ? STAT_STALE : STAT_ACCEPTED;
        if (!stale) begin
          w_gap   <= rx_seq_q - in_seq - SEQ_W'(1);
          w_acked <= acked;
        end
      end
    end
    if (dp_cmd.scale) scaled_q <= SCALE_W'(used_q) * SCALE_W'(gain);
    if (dp_cmd.cost)  cost_q   <= COST_W'(scaled_q) * COST_W'(cfg.ticks_per_byte);
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_out) begin
      status          <= w_status;
      header_first    <= w_hdr1;
      header_second   <= w_hdr2;
      packet_bytes    <= w_bytes;
      sent_reliable   <= w_sent_rel;
      took_pending    <= w_took;
      unreliable_sent <= w_unrel;
      dropped_gap     <= w_gap;
      reliable_acked  <= w_acked;
      can_packet      <= choke_free;
      can_reliable    <= choke_free && (reliable_bytes == '0);
    end
  end

endmodule

[hw/rtl/reliable_datagram_sequencer_unit.sv]
// Top level of the reliable datagram sequencer: APB registers, controller and datapath.
// Depends on rds_pkg, rds_regs, rds_ctrl and rds_dp.
//
// One item is in work at a time. A transmit item passes from acceptance
// through the decide step, two registered multiply steps for the byte-rate
// cost, the 48-bit clear-time update and the result load before its result is
// valid; a receive item or an overflow refusal goes from decide straight to
// the result load. The rate cost multiply chain and the clear-time add set the
// transmit latency. The input is ready again the cycle after the result loads,
// so a new item is not taken before the last one's result has loaded. A finished
// result waits in an output register, and the next item is accepted while it
// waits; a result that cannot be loaded holds the controller in its final step.
module reliable_datagram_sequencer_unit import rds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [TIME_W-1:0] now_time,
  input  logic [SEQ_W-1:0]  rx_sequence,
  input  logic              rx_has_reliable,
  input  logic [SEQ_W-1:0]  rx_ack_sequence,
  input  logic              rx_ack_bit,
  input  logic [LEN_W-1:0]  pending_length,
  input  logic [LEN_W-1:0]  unreliable_length,
  input  logic              message_overflow,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [31:0]       header_first,
  output logic [31:0]       header_second,
  output logic [LEN_W-1:0]  packet_bytes,
  output logic              sent_reliable,
  output logic              took_pending,
  output logic              unreliable_sent,
  output logic [SEQ_W-1:0]  dropped_gap,
  output logic              reliable_acked,
  output logic              can_packet,
  output logic              can_reliable
);

  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  rds_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  rds_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .dp_cmd            (dp_cmd),
    .dp_status         (dp_status),
    .operation         (operation),
    .now_time          (now_time),
    .rx_sequence       (rx_sequence),
    .rx_has_reliable   (rx_has_reliable),
    .rx_ack_sequence   (rx_ack_sequence),
    .rx_ack_bit        (rx_ack_bit),
    .pending_length    (pending_length),
    .unreliable_length (unreliable_length),
    .message_overflow  (message_overflow),
    .status            (status),
    .header_first      (header_first),
    .header_second     (header_second),
    .packet_bytes      (packet_bytes),
    .sent_reliable     (sent_reliable),
    .took_pending      (took_pending),
    .unreliable_sent   (unreliable_sent),
    .dropped_gap       (dropped_gap),
    .reliable_acked    (reliable_acked),
    .can_packet        (can_packet),
    .can_reliable      (can_reliable)
  );

endmodule
